// ===== src/vdpt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the virtual DMA position tracker: widths, codes, constants,
// and the sequencer state type. No dependencies.
package vdpt_pkg;

  // Field and register widths
  localparam int TIME_W  = 64;
  localparam int RATE_W  = 20;
  localparam int SIZE_W  = 21;
  localparam int POS_W   = 20;
  localparam int STATE_W = 2;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  // Time and rate constants
  localparam int TICKS_PER_MS = 10000;
  localparam int MS_PER_SEC   = 1000;
  localparam logic [SIZE_W-1:0] MAX_BUF = SIZE_W'(1 << POS_W);

  // Remainder register holds values below TICKS_PER_MS
  localparam int DIVR_W = 14;
  localparam int TREM_W = 14;
  localparam int BREM_W = 10;

  // Shared divider: 72-bit dividend, 4 quotient bits per cycle
  localparam int DIV_W    = 72;
  localparam int DIGIT    = 4;
  localparam int STEP_CNT = DIV_W / DIGIT;
  localparam int CNT_W    = $clog2(STEP_CNT);

  // Milliseconds fit in 51 bits; multiplied in two slices
  localparam int MS_W     = 51;
  localparam int MS_LO_W  = 26;
  localparam int MS_HI_W  = MS_W - MS_LO_W;
  localparam int PROD_W   = MS_LO_W + RATE_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_RATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'd1;

  // Register reset values
  localparam logic [RATE_W-1:0] BYTE_RATE_RST   = RATE_W'(192000);
  localparam logic [SIZE_W-1:0] BUFFER_SIZE_RST = SIZE_W'(65536);

  // Opcodes
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_SET   = 1'b1;

  // Requested state codes
  localparam logic [REQ_W-1:0] REQ_STOP    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PAUSE   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RUN     = 2'd3;

  // Reported stream state codes
  localparam logic [STATE_W-1:0] ST_STOP  = 2'd0;
  localparam logic [STATE_W-1:0] ST_PAUSE = 2'd1;
  localparam logic [STATE_W-1:0] ST_RUN   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_T,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_DIV_N
  } fsm_state_t;

endpackage

// ===== src/vdpt_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the position tracker: valid/ready plus one item.
// Depends on vdpt_pkg.
interface vdpt_in_if import vdpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [REQ_W-1:0]    new_state;
  logic [TIME_W-1:0]   current_time;

  modport source (output valid, output opcode, output new_state,
                  output current_time, input ready);
  modport sink   (input valid, input opcode, input new_state,
                  input current_time, output ready);
endinterface

// ===== src/vdpt_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the position tracker: valid/ready plus one result.
// Depends on vdpt_pkg.
interface vdpt_out_if import vdpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    position;
  logic [STATE_W-1:0]  run_state;

  modport source (output valid, output position, output run_state,
                  input ready);
  modport sink   (input valid, input position, input run_state,
                  output ready);
endinterface

// ===== src/virtual_dma_position_tracker.sv =====
`timescale 1ns / 1ps
// A state change, or a query while not running, gives its result in the
// cycle after the beat is taken. A query while running goes through the
// shared divider (two 72-bit divisions at 4 bits per cycle) and the 26x20
// multiplier used for two slices of the ms count; the next beat is taken
// once the result is out.
// Reset (rst_n, synchronous): stopped, position 0, rate 192000, size 65536.
module virtual_dma_position_tracker import vdpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  vdpt_in_if.sink                in_ch,
  vdpt_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration
  logic [RATE_W-1:0]  byte_rate_r;
  logic [SIZE_W-1:0]  buffer_size_r;
  logic [SIZE_W-1:0]  size_eff;

  // Stream state
  logic [STATE_W-1:0] st_r, st_nxt;
  logic               adv_r, adv_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [TREM_W-1:0]  trem_r, trem_nxt;
  logic [BREM_W-1:0]  brem_r, brem_nxt;
  logic [TIME_W-1:0]  last_ts_r, last_ts_nxt;

  // Sequencer and datapath
  fsm_state_t         fsm_r, fsm_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [DIVR_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]   qmod_r, qmod_nxt;
  logic [DIV_W-1:0]   acc_r, acc_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [STATE_W-1:0] out_st_r, out_st_nxt;

  // Shared unit signals
  logic [DIVR_W-1:0]  dvsr;
  logic [DIVR_W-1:0]  step_rem;
  logic [POS_W-1:0]   step_qmod;
  logic [DIGIT-1:0]   step_qnib;
  logic [MS_LO_W-1:0] mul_a;
  logic [PROD_W-1:0]  prod;
  logic [MS_W-1:0]    ms;
  logic               in_fire;
  logic               last_step;
  logic [STATE_W-1:0] target;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign last_step = (cnt_r == CNT_W'(STEP_CNT - 1));
  assign ms        = div_r[MS_W-1:0];

  // Wrap length: zero counts as one, clamp at the 20-bit range
  always_comb begin
    if (buffer_size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (buffer_size_r > MAX_BUF) begin
      size_eff = MAX_BUF;
    end else begin
      size_eff = buffer_size_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_rate_r   <= BYTE_RATE_RST;
      buffer_size_r <= BUFFER_SIZE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BYTE_RATE) begin
        byte_rate_r <= cfg_data[RATE_W-1:0];
      end
      if (cfg_index == CFG_BUFFER_SIZE) begin
        buffer_size_r <= cfg_data[SIZE_W-1:0];
      end
    end
  end

  // Divisor: ticks per ms in the first pass, ms per second in the second
  assign dvsr = (fsm_r == S_DIV_T) ? DIVR_W'(TICKS_PER_MS) : DIVR_W'(MS_PER_SEC);

  // Shared divide step: four restoring steps, quotient bits also folded
  // into the running quotient modulo the buffer size
  always_comb begin : div_step
    logic [DIVR_W:0] part;
    logic [SIZE_W-1:0] mpart;
    logic qbit;
    step_rem  = rem_r;
    step_qmod = qmod_r;
    step_qnib = '0;
    for (int i = 0; i < DIGIT; i++) begin
      part = {step_rem, div_r[DIV_W-1-i]};
      qbit = (part >= {1'b0, dvsr});
      if (qbit) begin
        part = part - {1'b0, dvsr};
      end
      step_rem = part[DIVR_W-1:0];
      step_qnib[DIGIT-1-i] = qbit;
      mpart = {step_qmod, qbit};
      if (mpart >= size_eff) begin
        mpart = mpart - size_eff;
      end
      step_qmod = mpart[POS_W-1:0];
    end
  end

  // Shared multiplier: rate times one slice of the ms count
  assign mul_a = (fsm_r == S_MUL1) ? ms[MS_LO_W-1:0] : MS_LO_W'(ms[MS_W-1:MS_LO_W]);
  assign prod  = PROD_W'(mul_a) * PROD_W'(byte_rate_r);

  // Requested state: acquire counts as stop
  always_comb begin
    case (in_ch.new_state)
      REQ_RUN:   target = ST_RUN;
      REQ_PAUSE: target = ST_PAUSE;
      default:   target = ST_STOP;
    endcase
  end

  assign in_ch.ready = (fsm_r == S_IDLE) && (!out_valid_r || out_ch.ready);

  // Sequencer: next state and datapath
  always_comb begin
    fsm_nxt       = fsm_r;
    cnt_nxt       = cnt_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    qmod_nxt      = qmod_r;
    acc_nxt       = acc_r;
    st_nxt        = st_r;
    adv_nxt       = adv_r;
    pos_nxt       = pos_r;
    trem_nxt      = trem_r;
    brem_nxt      = brem_r;
    last_ts_nxt   = last_ts_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_st_nxt    = out_st_r;

    unique case (fsm_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == OP_SET) begin
            if (target != st_r) begin
              st_nxt = target;
              if (target == ST_PAUSE) begin
                adv_nxt = 1'b0;
              end else if (target == ST_RUN) begin
                last_ts_nxt = in_ch.current_time;
                trem_nxt    = '0;
                adv_nxt     = 1'b1;
              end else begin
                adv_nxt  = 1'b0;
                pos_nxt  = '0;
                trem_nxt = '0;
                brem_nxt = '0;
              end
            end
            out_valid_nxt = 1'b1;
            out_pos_nxt   = pos_nxt;
            out_st_nxt    = st_nxt;
          end else if (adv_r) begin
            // Elapsed ticks, modulo 2^64
            div_nxt     = DIV_W'(in_ch.current_time - last_ts_r);
            last_ts_nxt = in_ch.current_time;
            fsm_nxt     = S_PREP;
          end else begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = pos_r;
            out_st_nxt    = st_r;
          end
        end
      end
      S_PREP: begin
        // Add the carried tick remainder at full width
        div_nxt  = DIV_W'(65'(div_r[TIME_W-1:0]) + 65'(trem_r));
        rem_nxt  = '0;
        qmod_nxt = '0;
        cnt_nxt  = '0;
        fsm_nxt  = S_DIV_T;
      end
      S_DIV_T: begin
        div_nxt = {div_r[DIV_W-DIGIT-1:0], step_qnib};
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_step) begin
          trem_nxt = step_rem[TREM_W-1:0];
          fsm_nxt  = S_MUL0;
        end
      end
      S_MUL0: begin
        // Fold the position in: (N + 1000*pos) / 1000 = pos + N / 1000
        acc_nxt = DIV_W'(30'(pos_r) * 30'(MS_PER_SEC)) + DIV_W'(brem_r);
        fsm_nxt = S_MUL1;
      end
      S_MUL1: begin
        acc_nxt = acc_r + DIV_W'(prod);
        fsm_nxt = S_MUL2;
      end
      S_MUL2: begin
        div_nxt  = acc_r + (DIV_W'(prod) << MS_LO_W);
        rem_nxt  = '0;
        qmod_nxt = '0;
        cnt_nxt  = '0;
        fsm_nxt  = S_DIV_N;
      end
      S_DIV_N: begin
        div_nxt  = {div_r[DIV_W-DIGIT-1:0], step_qnib};
        rem_nxt  = step_rem;
        qmod_nxt = step_qmod;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (last_step) begin
          brem_nxt      = step_rem[BREM_W-1:0];
          pos_nxt       = step_qmod;
          out_valid_nxt = 1'b1;
          out_pos_nxt   = step_qmod;
          out_st_nxt    = st_r;
          fsm_nxt       = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      st_r        <= ST_STOP;
      adv_r       <= 1'b0;
      pos_r       <= '0;
      trem_r      <= '0;
      brem_r      <= '0;
      last_ts_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      fsm_r       <= fsm_nxt;
      st_r        <= st_nxt;
      adv_r       <= adv_nxt;
      pos_r       <= pos_nxt;
      trem_r      <= trem_nxt;
      brem_r      <= brem_nxt;
      last_ts_r   <= last_ts_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    qmod_r    <= qmod_nxt;
    acc_r     <= acc_nxt;
    out_pos_r <= out_pos_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.run_state = out_st_r;

  // Checks
  a_adv_run: assert property (@(posedge clk) disable iff (!rst_n)
    adv_r |-> (st_r == ST_RUN))
    else $error("advancing while not running");

  a_rem_t: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_DIV_T) |-> (rem_r < DIVR_W'(TICKS_PER_MS)))
    else $error("tick remainder out of range");

  a_rem_n: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_DIV_N) |-> ((rem_r < DIVR_W'(MS_PER_SEC)) && (SIZE_W'(qmod_r) < size_eff)))
    else $error("byte remainder or wrapped quotient out of range");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((fsm_r == S_DIV_N) && last_step) |=> (out_ch.valid && (fsm_r == S_IDLE)))
    else $error("query result not delivered at end of sequence");

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((fsm_r != S_IDLE) && (fsm_r != S_PREP)) |-> !out_valid_r)
    else $error("result register occupied during computation");

endmodule
